// ----- rtl/rzs_pkg.sv -----
package rzs_pkg;

    localparam int TEX_WIDTH  = 320;
    localparam int TEX_HEIGHT = 200;
    localparam int FRAC_BITS  = 10;
    localparam int SCR_W      = 320;
    localparam int SCR_H      = 200;

    localparam int TEX_SIZE = TEX_WIDTH * TEX_HEIGHT;
    localparam int SCR_SIZE = SCR_W * SCR_H;

    localparam int ACC_W     = 32;
    localparam int STEP_W    = 18;
    localparam int PIX_W     = 8;
    localparam int TIDX_W    = 16;
    localparam int SIDX_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int MEM_AW = $clog2(TEX_SIZE);
    localparam int COL_W  = $clog2(SCR_W);
    localparam int ROW_W  = $clog2(SCR_H);
    localparam int TX_W   = $clog2(TEX_WIDTH);
    localparam int TY_W   = $clog2(TEX_HEIGHT);

    // integer part of an accumulator, and the same part lifted to non-negative
    localparam int INT_W = ACC_W - FRAC_BITS;
    localparam int X_W   = INT_W + 1;

    // offsets are whole multiples of the texture size, so floor modulo is kept
    localparam int OFF_U = ((2 ** (INT_W - 1) + TEX_WIDTH - 1) / TEX_WIDTH) * TEX_WIDTH;
    localparam int OFF_V = ((2 ** (INT_W - 1) + TEX_HEIGHT - 1) / TEX_HEIGHT) * TEX_HEIGHT;

    // reciprocal estimate of x / size, at most one low
    localparam int RCP_SH  = X_W + 1;
    localparam int RCP_U   = 2 ** RCP_SH / TEX_WIDTH;
    localparam int RCP_V   = 2 ** RCP_SH / TEX_HEIGHT;
    localparam int RCP_U_W = $clog2(RCP_U + 1);
    localparam int RCP_V_W = $clog2(RCP_V + 1);
    localparam int QU_W    = X_W + RCP_U_W - RCP_SH;
    localparam int QV_W    = X_W + RCP_V_W - RCP_SH;

    localparam int HALF_W = SCR_W / 2;
    localparam int HALF_H = SCR_H / 2;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } rzs_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COS = CFG_IDX_W'(1);

    localparam logic signed [STEP_W-1:0] STEP_SIN_RST = '0;
    localparam logic signed [STEP_W-1:0] STEP_COS_RST = STEP_W'(1 << FRAC_BITS);

    typedef struct packed
    {
        logic load_quot;
        logic load_rem;
    } rzs_adv_t;

    function automatic logic [ACC_W-1:0] origin_u(input logic signed [STEP_W-1:0] s,
                                                   input logic signed [STEP_W-1:0] c);
        logic signed [ACC_W-1:0] se;
        logic signed [ACC_W-1:0] ce;
        se = ACC_W'(s);
        ce = ACC_W'(c);
        return ACC_W'(HALF_H * se - HALF_W * ce + (HALF_W << FRAC_BITS));
    endfunction

    function automatic logic [ACC_W-1:0] origin_v(input logic signed [STEP_W-1:0] s,
                                                   input logic signed [STEP_W-1:0] c);
        logic signed [ACC_W-1:0] se;
        logic signed [ACC_W-1:0] ce;
        se = ACC_W'(s);
        ce = ACC_W'(c);
        return ACC_W'((HALF_H << FRAC_BITS) - HALF_W * se - HALF_H * ce);
    endfunction

    localparam logic [ACC_W-1:0] ORIGIN_U_RST = origin_u(STEP_SIN_RST, STEP_COS_RST);
    localparam logic [ACC_W-1:0] ORIGIN_V_RST = origin_v(STEP_SIN_RST, STEP_COS_RST);

endpackage

// ----- rtl/rzs_wrap.sv -----
module rzs_wrap
(
    input  logic                         clk,
    input  rzs_pkg::rzs_adv_t            adv,
    input  logic [rzs_pkg::X_W-1:0]      x_u,
    input  logic [rzs_pkg::X_W-1:0]      x_v,
    output logic [rzs_pkg::TX_W-1:0]     tx,
    output logic [rzs_pkg::TY_W-1:0]     ty
);

    localparam int PU_W = rzs_pkg::X_W + rzs_pkg::RCP_U_W;
    localparam int PV_W = rzs_pkg::X_W + rzs_pkg::RCP_V_W;

    logic [PU_W-1:0]              prod_u;
    logic [PV_W-1:0]              prod_v;
    logic [rzs_pkg::X_W-1:0]      x_u_reg;
    logic [rzs_pkg::X_W-1:0]      x_v_reg;
    logic [rzs_pkg::QU_W-1:0]     qu_reg;
    logic [rzs_pkg::QV_W-1:0]     qv_reg;
    logic [rzs_pkg::X_W-1:0]      ru;
    logic [rzs_pkg::X_W-1:0]      rv;
    logic [rzs_pkg::X_W-1:0]      ru_fix;
    logic [rzs_pkg::X_W-1:0]      rv_fix;
    logic [rzs_pkg::TX_W-1:0]     tx_reg;
    logic [rzs_pkg::TY_W-1:0]     ty_reg;

    assign prod_u = PU_W'(x_u) * PU_W'(rzs_pkg::RCP_U);
    assign prod_v = PV_W'(x_v) * PV_W'(rzs_pkg::RCP_V);

    always_ff @(posedge clk)
    begin
        if (adv.load_quot)
        begin
            x_u_reg <= x_u;
            x_v_reg <= x_v;
            qu_reg  <= prod_u[PU_W-1:rzs_pkg::RCP_SH];
            qv_reg  <= prod_v[PV_W-1:rzs_pkg::RCP_SH];
        end
    end

    // remainder below twice the size: one correction
    always_comb
    begin
        ru = x_u_reg - rzs_pkg::X_W'(qu_reg * rzs_pkg::TEX_WIDTH);
        rv = x_v_reg - rzs_pkg::X_W'(qv_reg * rzs_pkg::TEX_HEIGHT);
        ru_fix = ru;
        rv_fix = rv;
        if (ru >= rzs_pkg::X_W'(rzs_pkg::TEX_WIDTH))
        begin
            ru_fix = ru - rzs_pkg::X_W'(rzs_pkg::TEX_WIDTH);
        end
        if (rv >= rzs_pkg::X_W'(rzs_pkg::TEX_HEIGHT))
        begin
            rv_fix = rv - rzs_pkg::X_W'(rzs_pkg::TEX_HEIGHT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_rem)
        begin
            tx_reg <= ru_fix[rzs_pkg::TX_W-1:0];
            ty_reg <= rv_fix[rzs_pkg::TY_W-1:0];
        end
    end

    assign tx = tx_reg;
    assign ty = ty_reg;

endmodule

// ----- rtl/rotozoom_texture_sampler_unit.sv -----
// Throughput: one request per cycle unless rsp_stall holds the pipeline; a texel write takes a slot and gives no pixel.
// The pipeline is accumulate, reciprocal multiply, remainder, address, texture read.
// Reset clears valids and raster position, loads the origins and sets identity steps.
// Texture contents are undefined until written; there is no clearing pass.
module rotozoom_texture_sampler_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                operation,
    input  logic [rzs_pkg::TIDX_W-1:0]          texel_index,
    input  logic [rzs_pkg::PIX_W-1:0]           texel_value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [rzs_pkg::PIX_W-1:0]           pixel_value,
    output logic [rzs_pkg::SIDX_W-1:0]          screen_index,
    output logic                                frame_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rzs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rzs_pkg::STEP_W-1:0]          cfg_data
);

    localparam int ACC_W = rzs_pkg::ACC_W;

    logic signed [rzs_pkg::STEP_W-1:0] step_sin_reg, step_sin_next;
    logic signed [rzs_pkg::STEP_W-1:0] step_cos_reg, step_cos_next;
    logic [ACC_W-1:0] origin_u_reg, origin_v_reg;
    logic [ACC_W-1:0] row_u_reg, row_v_reg, pix_u_reg, pix_v_reg;
    logic [rzs_pkg::COL_W-1:0]  col_reg;
    logic [rzs_pkg::ROW_W-1:0]  row_reg;
    logic [rzs_pkg::SIDX_W-1:0] scr_reg;

    logic cfg_wr;
    logic acc_req, render;
    logic col_first, row_first, col_last, row_last, frame_last;
    logic [ACC_W-1:0] s_ext, c_ext, row_u_cur, row_v_cur, cur_u, cur_v;
    logic [rzs_pkg::X_W-1:0] x_u_next, x_v_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    rzs_pkg::rzs_op_t op1_reg, op2_reg, op3_reg, op4_reg;
    logic [rzs_pkg::X_W-1:0] x_u1_reg, x_v1_reg;
    logic [rzs_pkg::TIDX_W-1:0] widx1_reg, widx2_reg, widx3_reg;
    logic [rzs_pkg::PIX_W-1:0]  wval1_reg, wval2_reg, wval3_reg, wval4_reg;
    logic [rzs_pkg::SIDX_W-1:0] scr1_reg, scr2_reg, scr3_reg, scr4_reg, scr5_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;
    logic [rzs_pkg::MEM_AW-1:0] addr4_reg;
    logic wen4_reg;
    logic out_valid_reg;
    logic [rzs_pkg::PIX_W-1:0] rd_data_reg;

    logic [rzs_pkg::TX_W-1:0] tx;
    logic [rzs_pkg::TY_W-1:0] ty;
    rzs_pkg::rzs_adv_t adv;

    logic [rzs_pkg::PIX_W-1:0] tex_mem [rzs_pkg::TEX_SIZE];

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        step_sin_next = step_sin_reg;
        step_cos_next = step_cos_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                rzs_pkg::REG_STEP_SIN: step_sin_next = cfg_data;
                rzs_pkg::REG_STEP_COS: step_cos_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_sin_reg <= rzs_pkg::STEP_SIN_RST;
            step_cos_reg <= rzs_pkg::STEP_COS_RST;
            origin_u_reg <= rzs_pkg::ORIGIN_U_RST;
            origin_v_reg <= rzs_pkg::ORIGIN_V_RST;
        end
        else if (cfg_wr)
        begin
            step_sin_reg <= step_sin_next;
            step_cos_reg <= step_cos_next;
            origin_u_reg <= rzs_pkg::origin_u(step_sin_next, step_cos_next);
            origin_v_reg <= rzs_pkg::origin_v(step_sin_next, step_cos_next);
        end
    end

    // flow control
    assign rdy5 = !out_valid_reg || !rsp_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign req_stall = !rdy1;
    assign acc_req   = req_valid && !req_stall;
    assign render    = acc_req && (operation == rzs_pkg::OP_RENDER);

    // affine walk
    assign col_first  = col_reg == '0;
    assign row_first  = row_reg == '0;
    assign col_last   = col_reg == rzs_pkg::COL_W'(rzs_pkg::SCR_W - 1);
    assign row_last   = row_reg == rzs_pkg::ROW_W'(rzs_pkg::SCR_H - 1);
    assign frame_last = col_last && row_last;

    assign s_ext     = ACC_W'(step_sin_reg);
    assign c_ext     = ACC_W'(step_cos_reg);
    assign row_u_cur = row_first ? origin_u_reg : row_u_reg;
    assign row_v_cur = row_first ? origin_v_reg : row_v_reg;
    assign cur_u     = col_first ? row_u_cur : pix_u_reg;
    assign cur_v     = col_first ? row_v_cur : pix_v_reg;

    assign x_u_next = rzs_pkg::X_W'($signed(cur_u[ACC_W-1:rzs_pkg::FRAC_BITS]))
                    + rzs_pkg::X_W'(rzs_pkg::OFF_U);
    assign x_v_next = rzs_pkg::X_W'($signed(cur_v[ACC_W-1:rzs_pkg::FRAC_BITS]))
                    + rzs_pkg::X_W'(rzs_pkg::OFF_V);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_u_reg <= rzs_pkg::ORIGIN_U_RST;
            row_v_reg <= rzs_pkg::ORIGIN_V_RST;
            pix_u_reg <= '0;
            pix_v_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            scr_reg   <= '0;
        end
        else if (render)
        begin
            pix_u_reg <= cur_u + c_ext;
            pix_v_reg <= cur_v + s_ext;
            if (col_first && row_first)
            begin
                row_u_reg <= origin_u_reg;
                row_v_reg <= origin_v_reg;
            end
            if (col_last)
            begin
                row_u_reg <= row_u_reg - s_ext;
                row_v_reg <= row_v_reg + c_ext;
                col_reg   <= '0;
                row_reg   <= row_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
            scr_reg <= frame_last ? '0 : scr_reg + 1'b1;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= acc_req;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) out_valid_reg <= v4_reg && (op4_reg == rzs_pkg::OP_RENDER);
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (acc_req)
        begin
            op1_reg   <= rzs_pkg::rzs_op_t'(operation);
            x_u1_reg  <= x_u_next;
            x_v1_reg  <= x_v_next;
            widx1_reg <= texel_index;
            wval1_reg <= texel_value;
            scr1_reg  <= scr_reg;
            last1_reg <= frame_last;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg   <= op1_reg;
            widx2_reg <= widx1_reg;
            wval2_reg <= wval1_reg;
            scr2_reg  <= scr1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            op3_reg   <= op2_reg;
            widx3_reg <= widx2_reg;
            wval3_reg <= wval2_reg;
            scr3_reg  <= scr2_reg;
            last3_reg <= last2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            op4_reg   <= op3_reg;
            wval4_reg <= wval3_reg;
            scr4_reg  <= scr3_reg;
            last4_reg <= last3_reg;
            wen4_reg  <= (op3_reg == rzs_pkg::OP_WRITE)
                      && (32'(widx3_reg) < rzs_pkg::TEX_SIZE);
            if (op3_reg == rzs_pkg::OP_RENDER)
            begin
                addr4_reg <= rzs_pkg::MEM_AW'(ty * rzs_pkg::TEX_WIDTH)
                           + rzs_pkg::MEM_AW'(tx);
            end
            else
            begin
                addr4_reg <= rzs_pkg::MEM_AW'(widx3_reg);
            end
        end
        if (rdy5 && v4_reg && (op4_reg == rzs_pkg::OP_RENDER))
        begin
            scr5_reg  <= scr4_reg;
            last5_reg <= last4_reg;
        end
    end

    assign adv.load_quot = rdy2 && v1_reg;
    assign adv.load_rem  = rdy3 && v2_reg;

    rzs_wrap u_wrap
    (
        .clk (clk),
        .adv (adv),
        .x_u (x_u1_reg),
        .x_v (x_v1_reg),
        .tx  (tx),
        .ty  (ty)
    );

    // texture store: writes and reads stay in request order
    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            if (wen4_reg)
            begin
                tex_mem[addr4_reg] <= wval4_reg;
            end
            if (op4_reg == rzs_pkg::OP_RENDER)
            begin
                rd_data_reg <= tex_mem[addr4_reg];
            end
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign pixel_value  = rd_data_reg;
    assign screen_index = scr5_reg;
    assign frame_end    = last5_reg;

endmodule
